// ----- src/gbn_pkg.sv -----
// Go-Back-N sender package: constants, codes, payload and control structs.
// No dependencies; every other file of the block uses it.
package gbn_pkg;

  // Segmentation and window limits
  localparam int unsigned SEGMENT_BYTES = 1024;
  localparam int unsigned MAX_WINDOW    = 64;
  localparam int unsigned SEQ_MODULUS   = 65535;
  localparam logic [15:0] ACK_FLAG      = 16'h0002;

  // Widths
  localparam int unsigned SEG_SHIFT  = $clog2(SEGMENT_BYTES);
  localparam int unsigned MSG_W      = 24;
  localparam int unsigned WIN_CFG_W  = 7;
  localparam int unsigned TMO_W      = 32;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned SEQ_W      = 16;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned IDX_W      = MSG_W - SEG_SHIFT + 1;
  localparam int unsigned WIN_W      = $clog2(MAX_WINDOW + 1);

  // Register reset values
  localparam int unsigned WINDOW_RESET  = 20;
  localparam int unsigned TIMEOUT_RESET = 500;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MESSAGE_LENGTH = 2'd0,
    CFG_WINDOW_SIZE    = 2'd1,
    CFG_TIMEOUT_TICKS  = 2'd2
  } cfg_idx_e;

  // Result kinds
  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_END  = 1'b1
  } kind_e;

  // Input item
  typedef struct packed {
    logic        action;
    logic [15:0] ack_number;
    logic [15:0] ack_flags;
    logic        ack_checksum_ok;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic              kind;
    logic [SEQ_W-1:0]  seq_number;
    logic [MSG_W-1:0]  segment_offset;
    logic [LEN_W-1:0]  segment_length;
    logic              last;
  } out_item_t;

  // Classified event handed from front to back
  typedef struct packed {
    logic             is_ack;
    logic             ack_ok;
    logic [SEQ_W-1:0] ack_number;
  } event_t;

  // Derived configuration seen by the back end
  typedef struct packed {
    logic [IDX_W-1:0]     seg_count;
    logic [SEG_SHIFT-1:0] tail_bytes;
    logic [WIN_W-1:0]     window;
    logic [TMO_W-1:0]     timeout;
  } cfg_t;

  // Sender status
  typedef struct packed {
    logic             finished;
    logic [IDX_W-1:0] base;
    logic [IDX_W-1:0] next;
  } status_t;

  // Window size clamped to 1..MAX_WINDOW
  function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_CFG_W-1:0] w);
    logic [WIN_W-1:0] r;
    if (w == '0) begin
      r = WIN_W'(1);
    end else if (int'(w) > int'(MAX_WINDOW)) begin
      r = WIN_W'(MAX_WINDOW);
    end else begin
      r = WIN_W'(w);
    end
    return r;
  endfunction

endpackage

// ----- src/gbn_in_if.sv -----
// Input channel of the Go-Back-N sender: valid/ready with an input item.
// Depends on gbn_pkg.
interface gbn_in_if;
  logic               valid;
  logic               ready;
  gbn_pkg::in_item_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/gbn_out_if.sv -----
// Result channel of the Go-Back-N sender: valid/ready with a result item.
// Depends on gbn_pkg.
interface gbn_out_if;
  logic               valid;
  logic               ready;
  gbn_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/gbn_front.sv -----
// Front end: accepts input beats, classifies them and queues events.
// Depends on gbn_pkg and gbn_in_if.
module gbn_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  gbn_in_if.sink            in_i,
  output logic              ev_valid_o,
  output gbn_pkg::event_t   ev_o,
  input  logic              ev_pop_i
);

  gbn_pkg::event_t ev_q [2];
  logic            wptr_q, wptr_d;
  logic            rptr_q, rptr_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            push;
  gbn_pkg::event_t ev_new;

  // Classify: a valid ack needs good checksum, exact ACK flag and a real sequence number
  always_comb begin
    ev_new.is_ack     = in_i.payload.action;
    ev_new.ack_ok     = in_i.payload.action && in_i.payload.ack_checksum_ok &&
                        (in_i.payload.ack_flags == gbn_pkg::ACK_FLAG) &&
                        (in_i.payload.ack_number != 16'(gbn_pkg::SEQ_MODULUS));
    ev_new.ack_number = in_i.payload.ack_number;
  end

  assign in_i.ready = (cnt_q != 2'd2);
  assign push       = in_i.valid && in_i.ready;
  assign ev_valid_o = (cnt_q != 2'd0);
  assign ev_o       = ev_q[rptr_q];

  // Queue pointers
  always_comb begin
    wptr_d = push     ? ~wptr_q : wptr_q;
    rptr_d = ev_pop_i ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(push) - 2'(ev_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      ev_q[wptr_q] <= ev_new;
    end
  end

endmodule

// ----- src/gbn_back.sv -----
// Back end: window state update per event and a four-entry result queue.
// Depends on gbn_pkg and gbn_out_if.
module gbn_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbn_pkg::cfg_t     cfg_i,
  input  logic              ev_valid_i,
  input  gbn_pkg::event_t   ev_i,
  output logic              ev_pop_o,
  gbn_out_if.source         out_o,
  output gbn_pkg::status_t  status_o
);

  localparam int unsigned IW = gbn_pkg::IDX_W;

  logic [IW-1:0]             base_q, base_d;
  logic [IW-1:0]             next_q, next_d;
  logic [gbn_pkg::TMO_W-1:0] timer_q, timer_d;
  logic                      fin_q, fin_d;

  gbn_pkg::out_item_t ofifo_q [4];
  logic [1:0]         wptr_q, rptr_q;
  logic [2:0]         ocnt_q;
  logic               fire, opop;

  logic [IW-1:0]             next1;
  logic [gbn_pkg::TMO_W-1:0] timer1;
  logic [gbn_pkg::SEQ_W:0]   dsum, dmod;
  logic                      send, in_win, done_now;
  logic [IW-1:0]             base_adv;
  logic [1:0]                n_res;
  gbn_pkg::out_item_t        data_item, end_item, res0, res1;

  // Take an event only when two result slots are free
  assign fire     = ev_valid_i && (ocnt_q <= 3'd2);
  assign ev_pop_o = fire;

  // Window and timer update for one event
  always_comb begin
    base_d = base_q;
    next_d = next_q;
    timer_d = timer_q;
    fin_d  = fin_q;
    n_res  = 2'd0;

    done_now = (base_q >= cfg_i.seg_count);
    send     = ((next_q - base_q) < IW'(cfg_i.window)) && (next_q < cfg_i.seg_count);
    next1    = send ? next_q + IW'(1) : next_q;
    timer1   = send ? '0 : timer_q;

    // modular distance from base to the acked number
    dsum   = {1'b0, ev_i.ack_number} + 17'(gbn_pkg::SEQ_MODULUS) - 17'(base_q);
    dmod   = (dsum >= 17'(gbn_pkg::SEQ_MODULUS)) ? dsum - 17'(gbn_pkg::SEQ_MODULUS) : dsum;
    in_win = (dmod < 17'(cfg_i.window));
    base_adv = base_q + IW'(dmod[gbn_pkg::WIN_W-1:0]) + IW'(1);

    // data segment for next_q
    data_item.kind           = gbn_pkg::KIND_DATA;
    data_item.seq_number     = gbn_pkg::SEQ_W'(next_q);
    data_item.segment_offset = gbn_pkg::MSG_W'({next_q, gbn_pkg::SEG_SHIFT'(0)});
    if ((next_q == cfg_i.seg_count - IW'(1)) && (cfg_i.tail_bytes != '0)) begin
      data_item.segment_length = gbn_pkg::LEN_W'(cfg_i.tail_bytes);
    end else begin
      data_item.segment_length = gbn_pkg::LEN_W'(gbn_pkg::SEGMENT_BYTES);
    end
    data_item.last = 1'b0;

    end_item      = '0;
    end_item.kind = gbn_pkg::KIND_END;
    end_item.last = 1'b1;

    res0 = end_item;
    res1 = end_item;

    if (fire && !fin_q) begin
      if (done_now) begin
        n_res = 2'd1;
        fin_d = 1'b1;
      end else begin
        next_d  = next1;
        timer_d = timer1;
        if (ev_i.is_ack) begin
          if (ev_i.ack_ok && in_win) begin
            base_d = base_adv;
            if (next1 < base_adv) begin
              next_d = base_adv;
            end
          end
        end else begin
          if (timer1 != '1) begin
            timer_d = timer1 + gbn_pkg::TMO_W'(1);
          end
          if (timer_d > cfg_i.timeout) begin
            next_d = base_q;
          end
        end
        fin_d = (base_d >= cfg_i.seg_count);
        // result ordering: data first, end marker after
        if (send) begin
          res0 = data_item;
          if (fin_d) begin
            n_res = 2'd2;
          end else begin
            res0.last = 1'b1;
            n_res = 2'd1;
          end
        end else if (fin_d) begin
          n_res = 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      next_q  <= '0;
      timer_q <= '0;
      fin_q   <= 1'b0;
    end else begin
      base_q  <= base_d;
      next_q  <= next_d;
      timer_q <= timer_d;
      fin_q   <= fin_d;
    end
  end

  // Result queue
  assign out_o.valid   = (ocnt_q != 3'd0);
  assign out_o.payload = ofifo_q[rptr_q];
  assign opop          = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 2'd0;
      rptr_q <= 2'd0;
      ocnt_q <= 3'd0;
    end else begin
      wptr_q <= wptr_q + n_res;
      rptr_q <= rptr_q + 2'(opop);
      ocnt_q <= ocnt_q + 3'(n_res) - 3'(opop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_res != 2'd0) begin
      ofifo_q[wptr_q] <= res0;
    end
    if (n_res == 2'd2) begin
      ofifo_q[wptr_q + 2'd1] <= res1;
    end
  end

  assign status_o.finished = fin_q;
  assign status_o.base     = base_q;
  assign status_o.next     = next_q;

endmodule

// ----- src/go_back_n_window_sender_core.sv -----
// Go-Back-N sender top level: configuration registers, front end and back end.
// Depends on gbn_pkg, gbn_in_if, gbn_out_if, gbn_front and gbn_back.
//
//   channel | dir | beat carries                                           | handshake
//   in_i    | in  | action, ack_number, ack_flags, ack_checksum_ok        | valid/ready
//   out_o   | out | kind, seq_number, segment_offset, segment_length, last | valid/ready
//   cfg     | in  | cfg_idx_i, cfg_wdata_i                                 | cfg_we_i
//
// One input beat per cycle sustained while the event queue has room; an item's event is
// registered in the event queue and its results in the result queue, from which they are
// offered. An item with both a data segment and an end marker needs two output beats, so
// the output port sets the rate then (one result per cycle). Reset is immediate: no
// clearing pass. Front and back stall independently through a two-entry event queue; the
// back end waits for two free slots in its result queue.
module go_back_n_window_sender_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  gbn_in_if.sink                             in_i,
  gbn_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  gbn_pkg::cfg_t    cfg_q;
  gbn_pkg::event_t  ev;
  gbn_pkg::status_t status;
  logic             ev_valid, ev_pop;
  logic [gbn_pkg::MSG_W:0] len_round;

  // Segment count is rounded up at write time
  assign len_round = {1'b0, cfg_wdata_i[gbn_pkg::MSG_W-1:0]} +
                     (gbn_pkg::MSG_W+1)'(gbn_pkg::SEGMENT_BYTES - 1);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.seg_count  <= '0;
      cfg_q.tail_bytes <= '0;
      cfg_q.window     <= gbn_pkg::WIN_W'(gbn_pkg::WINDOW_RESET);
      cfg_q.timeout    <= gbn_pkg::TMO_W'(gbn_pkg::TIMEOUT_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        gbn_pkg::CFG_MESSAGE_LENGTH: begin
          cfg_q.seg_count  <= len_round[gbn_pkg::MSG_W:gbn_pkg::SEG_SHIFT];
          cfg_q.tail_bytes <= cfg_wdata_i[gbn_pkg::SEG_SHIFT-1:0];
        end
        gbn_pkg::CFG_WINDOW_SIZE: begin
          cfg_q.window <= gbn_pkg::eff_window(cfg_wdata_i[gbn_pkg::WIN_CFG_W-1:0]);
        end
        gbn_pkg::CFG_TIMEOUT_TICKS: begin
          cfg_q.timeout <= cfg_wdata_i[gbn_pkg::TMO_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  gbn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .ev_valid_o (ev_valid),
    .ev_o       (ev),
    .ev_pop_i   (ev_pop)
  );

  gbn_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .ev_valid_i (ev_valid),
    .ev_i       (ev),
    .ev_pop_o   (ev_pop),
    .out_o      (out_o),
    .status_o   (status)
  );

  // Send pointer never falls behind the window base
  a_next_ge_base: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.next >= status.base)
    else $error("send pointer below window base");

  // Finished is sticky
  a_fin_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.finished |=> status.finished)
    else $error("finished flag cleared");

  // No window movement after finish
  a_base_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.finished |=> $stable(status.base))
    else $error("window base moved after finish");

  // End marker always closes its item
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.payload.kind == gbn_pkg::KIND_END)) |-> out_o.payload.last)
    else $error("end marker without last");

endmodule
